### rtl/sce_pkg.sv
`default_nettype none

package sce_pkg;

  localparam int unsigned CFG_W = 5;
  localparam logic [CFG_W-1:0] LIMIT_RESET = 5'd28;

  localparam logic [7:0] STUFF_BYTE = 8'h60;
  localparam logic [7:0] STX_BYTE   = 8'h02;
  localparam logic [7:0] ETX_BYTE   = 8'h03;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one raw byte, already classified by the front end
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       dup;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPEND,
    ST_STX,
    ST_LEN,
    ST_PAY,
    ST_SUM,
    ST_ETX
  } back_state_t;

endpackage

`default_nettype wire

### rtl/sce_if.sv
`default_nettype none

interface sce_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       message_end;

  modport source (output valid, output data_byte, output message_end, input ready);
  modport sink   (input valid, input data_byte, input message_end, output ready);
endinterface

interface sce_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;
  logic       run_last;

  modport source (output valid, output out_byte, output frame_end, output run_last,
                  input ready);
  modport sink   (input valid, input out_byte, input frame_end, input run_last,
                  output ready);
endinterface

`default_nettype wire

### rtl/sce_front.sv
`default_nettype none

module sce_front
  import sce_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  sce_in_if.sink    in_ch,
  output item_t     item,
  output logic      item_valid,
  input  wire logic item_pop
);

  item_t              queue_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic               push;
  logic               pop;
  item_t              in_item;

  assign in_ch.ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign item_valid  = (count_r != '0);
  assign pop         = item_pop && item_valid;
  assign item        = queue_r[rd_ptr_r];

  always_comb begin
    in_item.data = in_ch.data_byte;
    in_item.last = in_ch.message_end;
    in_item.dup  = (in_ch.data_byte == STUFF_BYTE);
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

`default_nettype wire

### rtl/sce_back.sv
`default_nettype none

module sce_back
  import sce_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 28
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire item_t            item,
  input  wire logic             item_valid,
  output logic                  item_pop,
  input  wire logic [CFG_W-1:0] cfg_limit,
  sce_out_if.source             out_ch
);

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int unsigned FW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [7:0]  MAX8 = 8'(MAX_PAYLOAD);

  back_state_t    state_r, state_nxt;
  logic [7:0]     byte_r, byte_nxt;
  logic           last_r, last_nxt;
  logic [1:0]     left_r, left_nxt;
  logic [FW-1:0]  fill_r, fill_nxt;
  logic [7:0]     sum_r, sum_nxt;
  logic [AW-1:0]  idx_r, idx_nxt;

  logic [7:0]     mem [MAX_PAYLOAD];
  logic [7:0]     rd_data_r;
  logic           mem_we;

  logic           out_valid_r, out_valid_nxt;
  logic [7:0]     out_byte_r;
  logic           frame_end_r;
  logic           run_last_r;

  logic           emit_ok;
  logic           emit;
  logic [7:0]     emit_byte;
  logic           emit_fend;
  logic           emit_last;

  logic [7:0]     lim_eff;
  logic           fill_full;
  logic [FW-1:0]  fill_inc;
  logic           send_now;
  logic           pay_done;

  always_comb begin
    lim_eff = {{(8-CFG_W){1'b0}}, cfg_limit};
    if (lim_eff == 8'd0) begin
      lim_eff = 8'd1;
    end else if (lim_eff > MAX8) begin
      lim_eff = MAX8;
    end
  end

  // a full store takes no byte but still forces the frame out
  assign fill_full = (fill_r == FW'(MAX_PAYLOAD));
  assign fill_inc  = fill_full ? fill_r : fill_r + FW'(1);
  assign send_now  = (8'(fill_inc) >= lim_eff);
  assign pay_done  = ((FW'(idx_r) + FW'(1)) == fill_r);
  assign emit_ok   = !out_valid_r || out_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (item_valid) state_nxt = ST_APPEND;
      end
      ST_APPEND: begin
        if (send_now) begin
          state_nxt = ST_STX;
        end else if (left_r == 2'd2) begin
          state_nxt = ST_APPEND;
        end else if (last_r) begin
          state_nxt = ST_STX;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_STX: begin
        if (emit_ok) state_nxt = ST_LEN;
      end
      ST_LEN: begin
        if (emit_ok) state_nxt = ST_PAY;
      end
      ST_PAY: begin
        if (emit_ok && pay_done) state_nxt = ST_SUM;
      end
      ST_SUM: begin
        if (emit_ok) state_nxt = ST_ETX;
      end
      ST_ETX: begin
        if (emit_ok) state_nxt = (left_r != 2'd0) ? ST_APPEND : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    left_nxt  = left_r;
    fill_nxt  = fill_r;
    sum_nxt   = sum_r;
    idx_nxt   = idx_r;
    item_pop  = 1'b0;
    mem_we    = 1'b0;
    emit      = 1'b0;
    emit_byte = 8'd0;
    emit_fend = 1'b0;
    emit_last = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (item_valid) begin
          item_pop = 1'b1;
          byte_nxt = item.data;
          last_nxt = item.last;
          left_nxt = item.dup ? 2'd2 : 2'd1;
        end
      end
      ST_APPEND: begin
        mem_we   = !fill_full;
        fill_nxt = fill_inc;
        sum_nxt  = fill_full ? sum_r : sum_r + byte_r;
        left_nxt = left_r - 2'd1;
        idx_nxt  = '0;
      end
      ST_STX: begin
        emit      = emit_ok;
        emit_byte = STX_BYTE;
      end
      ST_LEN: begin
        emit      = emit_ok;
        emit_byte = 8'(fill_r);
      end
      ST_PAY: begin
        emit      = emit_ok;
        emit_byte = rd_data_r;
        if (emit_ok) idx_nxt = pay_done ? '0 : idx_r + AW'(1);
      end
      ST_SUM: begin
        emit      = emit_ok;
        emit_byte = sum_r;
      end
      ST_ETX: begin
        emit      = emit_ok;
        emit_byte = ETX_BYTE;
        emit_fend = 1'b1;
        // a pending doubled byte opens a new frame at once only for a
        // limit of one, or when the message ends and it gets flushed
        emit_last = !((left_r != 2'd0) && ((lim_eff == 8'd1) || last_r));
        if (emit_ok) begin
          fill_nxt = '0;
          sum_nxt  = 8'd0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      sum_r       <= 8'd0;
      idx_r       <= '0;
      left_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      idx_r       <= idx_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    if (emit) begin
      out_byte_r  <= emit_byte;
      frame_end_r <= emit_fend;
      run_last_r  <= emit_last;
    end
  end

  // no writes happen during STX/LEN, so the read of entry 0 is fresh by PAY
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[fill_r[AW-1:0]] <= byte_r;
    end
    rd_data_r <= mem[idx_nxt];
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.frame_end = frame_end_r;
  assign out_ch.run_last  = run_last_r;

endmodule

`default_nettype wire

### rtl/stuffed_checksum_frame_encoder.sv
`default_nettype none

// Frames a byte stream as STX, length, payload, 8-bit sum, ETX, doubling every
// 0x60 byte and cutting the stuffed stream into frames of at most cfg_wdata
// payload bytes (0 acts as 1, values above MAX_PAYLOAD act as MAX_PAYLOAD);
// the byte flagged message_end flushes any partial frame. Input beats land in
// a two-entry queue; the back end takes each byte through IDLE and APPEND
// (0x60 twice) and sends a closed frame from STX, LEN, PAY, SUM and ETX, one
// line byte per cycle through the output register unless out_ch.ready stalls
// it. run_last marks the last line byte caused by an input beat; beats that
// close no frame give no output. Write the limit only while the block is idle.
module stuffed_checksum_frame_encoder
  import sce_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 28
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  sce_in_if.sink                in_ch,
  sce_out_if.source             out_ch,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  logic [CFG_W-1:0] limit_r, limit_nxt;
  item_t            item;
  logic             item_valid;
  logic             item_pop;

  assign limit_nxt = cfg_we ? cfg_wdata : limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  sce_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop)
  );

  sce_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .cfg_limit  (limit_r),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire
